### rtl/u64alu_pkg.sv
// ----------------------------------------------------------------------------
// u64alu_pkg
// Shared types and constants for the 64-bit unsigned ALU core: opcode codes,
// controller states, partial-product selects and the command/status structs.
// ----------------------------------------------------------------------------
package u64alu_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned HalfW    = WordW / 2;
  localparam int unsigned OpW      = 3;
  localparam int unsigned ShW      = 7;
  localparam int unsigned InDataW  = 144;  // 3 + 64 + 64 + 7 = 138, padded to bytes
  localparam int unsigned OutDataW = 72;   // 64 + 1 + 1 + 1 = 67, padded to bytes
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Field offsets inside the input word
  localparam int unsigned InOpLsb = 0;
  localparam int unsigned InALsb  = InOpLsb + OpW;
  localparam int unsigned InBLsb  = InALsb + WordW;
  localparam int unsigned InShLsb = InBLsb + WordW;

  // Last multiply sequence step (three partial products, then final add)
  localparam logic [CntW-1:0] MulLastCnt = CntW'(3);
  localparam logic [CntW-1:0] DivLastCnt = CntW'(DivSteps - 1);

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_SHL = 3'd5,
    OP_SHR = 3'd6,
    OP_CMP = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  // Which 32x32 partial product the shared multiplier forms
  typedef enum logic [1:0] {
    PP_LO_LO = 2'd0,
    PP_LO_HI = 2'd1,
    PP_HI_LO = 2'd2
  } pp_sel_e;

  typedef struct packed {
    logic    load;       // capture the incoming word
    logic    div_step;   // one restoring-division step
    logic    mul_issue;  // register one partial product
    pp_sel_e pp_sel;
    logic    acc_first;  // accumulator takes the first partial product
    logic    acc_add;    // accumulator adds the registered partial product
    logic    out_load;   // load the output register
  } dp_cmd_t;

  typedef struct packed {
    opcode_e in_op;
    logic    in_b_zero;
  } dp_status_t;

endpackage

### rtl/u64alu_ctrl.sv
// ----------------------------------------------------------------------------
// u64alu_ctrl
// Sequencing FSM: takes one word at a time, runs the multiply or divide
// sequence on the datapath, and owns the output valid flag.
// ----------------------------------------------------------------------------
module u64alu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  u64alu_pkg::dp_status_t status_i,
  output u64alu_pkg::dp_cmd_t    cmd_o
);
  import u64alu_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          case (status_i.in_op)
            OP_MUL:         state_d = S_MUL;
            OP_DIV, OP_MOD: state_d = status_i.in_b_zero ? S_FIN : S_DIV;
            default:        state_d = S_FIN;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_issue = (cnt_q != MulLastCnt);
        cmd_o.pp_sel    = pp_sel_e'(cnt_q[1:0]);
        cmd_o.acc_first = (cnt_q == CntW'(1));
        cmd_o.acc_add   = (cnt_q > CntW'(1));
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == MulLastCnt) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLastCnt) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == DivLastCnt) |=> (state_q == S_FIN))
    else $error("divide sequence did not end after last step");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while full");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("output valid raised outside finish state");

endmodule

### rtl/u64alu_dp.sv
// ----------------------------------------------------------------------------
// u64alu_dp
// Datapath: operand registers, shared 32x32 multiplier with accumulator,
// radix-2 restoring divider, shifter, compare flags and output register.
// ----------------------------------------------------------------------------
module u64alu_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [u64alu_pkg::InDataW-1:0]     in_data_i,
  input  u64alu_pkg::dp_cmd_t                cmd_i,
  output u64alu_pkg::dp_status_t             status_o,
  output logic [u64alu_pkg::OutDataW-1:0]    out_data_o
);
  import u64alu_pkg::*;

  // Incoming fields
  opcode_e           in_op;
  logic [WordW-1:0]  in_a, in_b;
  logic [ShW-1:0]    in_sh;

  assign in_op = opcode_e'(in_data_i[InOpLsb +: OpW]);
  assign in_a  = in_data_i[InALsb +: WordW];
  assign in_b  = in_data_i[InBLsb +: WordW];
  assign in_sh = in_data_i[InShLsb +: ShW];

  assign status_o.in_op     = in_op;
  assign status_o.in_b_zero = (in_b == '0);

  // Operand and work registers
  opcode_e              op_q;
  logic [WordW-1:0]     a_q, b_q, work_q, work_d, rem_q, rem_d, prod_q, prod_d;
  logic [ShW-1:0]       sh_q;
  logic [OutDataW-1:0]  out_q, out_d;

  // Divider step: shift in next dividend bit, trial subtract
  logic [WordW:0]   div_r;
  logic [WordW+1:0] div_diff;
  logic             div_ge;

  assign div_r    = {rem_q, work_q[WordW-1]};
  assign div_diff = {1'b0, div_r} - {2'b00, b_q};
  assign div_ge   = !div_diff[WordW+1];

  // Shared multiplier
  logic [HalfW-1:0] mul_x, mul_y;
  logic [WordW-1:0] mul_p;

  always_comb begin
    case (cmd_i.pp_sel)
      PP_LO_LO: begin
        mul_x = a_q[HalfW-1:0];
        mul_y = b_q[HalfW-1:0];
      end
      PP_LO_HI: begin
        mul_x = a_q[HalfW-1:0];
        mul_y = b_q[WordW-1:HalfW];
      end
      PP_HI_LO: begin
        mul_x = a_q[WordW-1:HalfW];
        mul_y = b_q[HalfW-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p  = mul_x * mul_y;
  // cross terms only contribute their low half, moved up by 32
  assign prod_d = (cmd_i.pp_sel == PP_LO_LO) ? mul_p : {mul_p[HalfW-1:0], {HalfW{1'b0}}};

  // Work register / remainder next values
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      work_d = in_a;
      rem_d  = '0;
    end else if (cmd_i.div_step) begin
      work_d = {work_q[WordW-2:0], div_ge};
      rem_d  = div_ge ? div_diff[WordW-1:0] : div_r[WordW-1:0];
    end else if (cmd_i.acc_first) begin
      work_d = prod_q;
    end else if (cmd_i.acc_add) begin
      work_d = work_q + prod_q;
    end
  end

  // Final result select and flags
  logic [WordW-1:0] res;
  logic             b_zero, dz;

  assign b_zero = (b_q == '0);

  always_comb begin
    res = '0;
    dz  = 1'b0;
    case (op_q)
      OP_ADD: res = a_q + b_q;
      OP_SUB: res = a_q - b_q;
      OP_MUL: res = work_q;
      OP_DIV: begin
        dz  = b_zero;
        res = b_zero ? '0 : work_q;
      end
      OP_MOD: begin
        dz  = b_zero;
        res = b_zero ? a_q : rem_q;
      end
      OP_SHL: res = sh_q[ShW-1] ? '0 : (a_q << sh_q[ShW-2:0]);
      OP_SHR: res = sh_q[ShW-1] ? '0 : (a_q >> sh_q[ShW-2:0]);
      default: res = '0;
    endcase
  end

  assign out_d = {{(OutDataW-WordW-3){1'b0}}, dz, (a_q < b_q), (a_q == b_q), res};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_op;
      a_q  <= in_a;
      b_q  <= in_b;
      sh_q <= in_sh;
    end
    work_q <= work_d;
    rem_q  <= rem_d;
    if (cmd_i.mul_issue) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // Restoring division keeps the partial remainder below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < b_q))
    else $error("partial remainder not below divisor");

endmodule

### rtl/unsigned_64bit_alu_core.sv
// ----------------------------------------------------------------------------
// unsigned_64bit_alu_core
// Add, sub, shifts, compare and divide/modulo by zero go straight to the
// finish state; multiply uses the shared 32x32 multiplier for three partial
// products and a final add; divide/modulo runs one radix-2 step per cycle.
// One word in flight: the next word can be taken from the cycle after the
// result is registered. The output register holds a result while the next
// word is taken. Reset clears control state only.
// ----------------------------------------------------------------------------
module unsigned_64bit_alu_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] opcode, [66:3] operand_a, [130:67] operand_b,
  // [137:131] shift_amount, [143:138] zero
  input  logic [u64alu_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] result_value, [64] a_equals_b, [65] a_less_than_b,
  // [66] divide_by_zero, [71:67] zero
  output logic [u64alu_pkg::OutDataW-1:0] m_axis_tdata
);
  import u64alu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  u64alu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic datapath
  u64alu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (m_axis_tdata)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for unsigned_64bit_alu_core. A directed table covers the
// operand extremes, every opcode, divide and modulo by zero, large shifts and
// compare-only. It is followed by random words biased toward corner values
// and related operands. Every result word is checked field by field against
// the result written in its directed row or an in-bench predictor. The run
// passes through phases of sender idling and receiver stalling, and includes one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import u64alu_pkg::*;

  localparam int unsigned NUM_DIRECTED     = 25;
  localparam int unsigned ITEMS_PER_PHASE  = 310;
  localparam int unsigned NUM_PHASES       = 4;
  // Long hold-off starts once this many results are in (early in the no-idle phase)
  localparam int unsigned LONG_HOLD_AT     = 60;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // Worst quiet gap is the long hold plus one divide; allow plenty
  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  // Wait past the length of a divide for stray words
  localparam int unsigned DRAIN_CYCLES     = 80;
  localparam int unsigned MAX_REPORTS      = 40;

  localparam logic [WordW-1:0] ONES = '1;
  localparam logic [WordW-1:0] MSB  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    opcode_e          op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [ShW-1:0]   sh;
  } alu_cmd_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             eq;
    logic             lt;
    logic             dz;
  } alu_res_t;

  typedef struct packed {
    alu_cmd_t cmd;
    logic     typed;  // 1: use the result written in the row
    alu_res_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  alu_res_t pending_results [$];
  int       error_count    = 0;
  int       results_seen   = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  // Directed words: extremes, every opcode, zero divisors, large shifts
  dir_row_t dir_table [NUM_DIRECTED] = '{
    '{'{OP_ADD, 64'd0, 64'd0, 7'd0}, 1'b1, '{64'd0, 1'b1, 1'b0, 1'b0}},
    '{'{OP_ADD, ONES, 64'd1, 7'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADD, ONES, ONES, 7'd127}, 1'b0, '0},
    '{'{OP_SUB, 64'd0, 64'd1, 7'd0}, 1'b1, '{ONES, 1'b0, 1'b1, 1'b0}},
    '{'{OP_SUB, ONES, ONES, 7'd0}, 1'b0, '0},
    '{'{OP_MUL, ONES, ONES, 7'd0}, 1'b1, '{64'd1, 1'b1, 1'b0, 1'b0}},
    '{'{OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 7'd0}, 1'b1,
      '{64'd0, 1'b1, 1'b0, 1'b0}},
    '{'{OP_MUL, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 7'd0}, 1'b0, '0},
    '{'{OP_DIV, 64'd100, 64'd0, 7'd0}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b1}},
    '{'{OP_DIV, ONES, 64'd1, 7'd0}, 1'b0, '0},
    '{'{OP_DIV, 64'd5, ONES, 7'd0}, 1'b0, '0},
    '{'{OP_DIV, ONES, MSB, 7'd0}, 1'b0, '0},
    '{'{OP_MOD, 64'd12345, 64'd0, 7'd0}, 1'b1, '{64'd12345, 1'b0, 1'b0, 1'b1}},
    '{'{OP_MOD, ONES, ONES, 7'd0}, 1'b0, '0},
    '{'{OP_MOD, ONES, 64'hFFFF_FFFF, 7'd0}, 1'b0, '0},
    '{'{OP_DIV, 64'd0, 64'd0, 7'd0}, 1'b1, '{64'd0, 1'b1, 1'b0, 1'b1}},
    '{'{OP_SHL, ONES, 64'd0, 7'd0}, 1'b0, '0},
    '{'{OP_SHL, 64'd1, 64'd0, 7'd63}, 1'b0, '0},
    '{'{OP_SHL, ONES, 64'd0, 7'd64}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_SHL, ONES, 64'd0, 7'd127}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_SHR, ONES, 64'd0, 7'd63}, 1'b0, '0},
    '{'{OP_SHR, ONES, 64'd0, 7'd64}, 1'b1, '{64'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_SHR, MSB, 64'd0, 7'd1}, 1'b0, '0},
    '{'{OP_CMP, 64'd7, 64'd8, 7'd0}, 1'b1, '{64'd0, 1'b0, 1'b1, 1'b0}},
    '{'{OP_CMP, ONES, ONES, 7'd127}, 1'b1, '{64'd0, 1'b1, 1'b0, 1'b0}}
  };

  unsigned_64bit_alu_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Expected result word for one command
  function automatic alu_res_t alu_predict(alu_cmd_t c);
    alu_res_t r;
    r = '0;
    case (c.op)
      OP_ADD: r.value = c.a + c.b;
      OP_SUB: r.value = c.a - c.b;
      OP_MUL: r.value = c.a * c.b;  // low half of the product
      OP_DIV: begin
        if (c.b == '0) begin
          r.dz    = 1'b1;
          r.value = '0;
        end else begin
          r.value = c.a / c.b;
        end
      end
      OP_MOD: begin
        if (c.b == '0) begin
          r.dz    = 1'b1;
          r.value = c.a;
        end else begin
          r.value = c.a % c.b;
        end
      end
      OP_SHL: r.value = (c.sh >= WordW) ? '0 : c.a << c.sh;
      OP_SHR: r.value = (c.sh >= WordW) ? '0 : c.a >> c.sh;
      default: r.value = '0;  // compare only
    endcase
    r.eq = (c.a == c.b);
    r.lt = (c.a < c.b);
    return r;
  endfunction

  // Operand biased toward zero, all ones, small values and single bits
  function automatic logic [WordW-1:0] rand_word();
    logic [WordW-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = ONES;
      2:       w = WordW'($urandom_range(255));
      3:       w = 64'd1 << $urandom_range(63);
      4, 5:    w = w >> $urandom_range(63);
      default: ;
    endcase
    return w;
  endfunction

  function automatic alu_cmd_t rand_cmd();
    alu_cmd_t c;
    c.op = opcode_e'($urandom_range(7));
    c.a  = rand_word();
    // Neighbors of a exercise the equal and less-than flags at the boundary
    case ($urandom_range(9))
      0:       c.b = c.a;
      1:       c.b = c.a + 64'd1;
      2:       c.b = c.a - 64'd1;
      default: c.b = rand_word();
    endcase
    c.sh = ($urandom_range(3) == 0) ? ShW'($urandom_range(127)) : ShW'($urandom_range(63));
    return c;
  endfunction

  // Offer one word, wait for it to be taken, then queue its expected result
  task automatic send_cmd(alu_cmd_t c, logic typed, alu_res_t want);
    logic [InDataW-1:0] w;
    w = '0;
    w[InOpLsb +: OpW]   = c.op;
    w[InALsb  +: WordW] = c.a;
    w[InBLsb  +: WordW] = c.b;
    w[InShLsb +: ShW]   = c.sh;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(typed ? want : alu_predict(c));
  endtask

  task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    if (error_count < MAX_REPORTS)
      $display("ERROR: result %0d %s: got %h, expected %h", results_seen, what, got, want);
    error_count++;
  endtask

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    alu_cmd_t cmd;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i])
      send_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        cmd = rand_cmd();
        send_cmd(cmd, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // Result side: check each taken word, then drive tready for the next cycle
  initial begin : result_side
    alu_res_t want;
    int       hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[WordW-1:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[WordW-1:0] !== want.value)
            report_mismatch("result_value", m_axis_tdata[WordW-1:0], want.value);
          if (m_axis_tdata[WordW] !== want.eq)
            report_mismatch("a_equals_b", WordW'(m_axis_tdata[WordW]), WordW'(want.eq));
          if (m_axis_tdata[WordW+1] !== want.lt)
            report_mismatch("a_less_than_b", WordW'(m_axis_tdata[WordW+1]),
                            WordW'(want.lt));
          if (m_axis_tdata[WordW+2] !== want.dz)
            report_mismatch("divide_by_zero", WordW'(m_axis_tdata[WordW+2]),
                            WordW'(want.dz));
        end
        // One long hold-off so the core backs up and stalls its input
        if (results_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

### unsigned_64bit_alu_core.f
rtl/u64alu_pkg.sv
rtl/u64alu_ctrl.sv
rtl/u64alu_dp.sv
rtl/unsigned_64bit_alu_core.sv
tb/sv/tb_top.sv
